[rtl/kss_pkg.sv]
// kss_pkg: shared types and constants for the kruskal spanning tree selector
// used by the top level; depends on nothing
package kss_pkg;

	typedef struct packed {
		logic [5:0]  edge_from;
		logic [5:0]  edge_to;
		logic [31:0] effort;
		logic [31:0] profit;
		logic        last_edge;
	} edge_in_t;

	typedef struct packed {
		logic [8:0] edge_index;
		logic       valid_res;
		logic       last;
		logic       overflow;
	} result_t;

	localparam int unsigned RANK_MAX = 7;

endpackage

[rtl/kss_cmp.sv]
// kss_cmp: shared ordering compare, true when edge a goes strictly before b
// depends on nothing but its ports
module kss_cmp (
	input  logic [31:0] a_effort,
	input  logic [31:0] a_profit,
	input  logic [31:0] b_effort,
	input  logic [31:0] b_profit,
	output logic        before_ab
);
	always_comb begin
		if (a_effort != b_effort) begin
			before_ab = a_effort < b_effort;
		end else begin
			before_ab = a_profit > b_profit;
		end
	end
endmodule

[rtl/kruskal_spanning_tree_selector.sv]
// kruskal_spanning_tree_selector: top level, edge store, sort and union-find sequencer
// depends on kss_pkg and kss_cmp
//
// Edges are taken one per cycle while busy is low. The beat with last_edge
// starts a run: a stable insertion sort over the stored edges (effort
// ascending, profit descending, then arrival) using one shared compare
// unit, with O(n^2) compare and shift steps at worst. Before the scan the
// parent/rank stores are reset by a clearing pass over all MAX_VERTICES
// entries. The scan fetches each edge's sorted index and endpoints, walks
// both endpoints to their roots by following parent links and joins the
// roots when they differ. Each selection is held back one beat so that the
// final one can carry last. Results come out on res with res_strobe high
// for exactly one cycle; the receiver cannot stall. busy stays high until
// the run ends.
module kruskal_spanning_tree_selector #(
	parameter int MAX_EDGES    = 256,
	parameter int MAX_VERTICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  kss_pkg::edge_in_t  edge_in,
	output logic               res_strobe,
	output kss_pkg::result_t   res,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata
);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int VW = $clog2(MAX_VERTICES);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_SI    = 11'b00000000010, // outer sort step: fetch key
		S_SRD   = 11'b00000000100, // read sorted[k-1] index
		S_SRD2  = 11'b00000001000, // read its keys
		S_SCMP  = 11'b00000010000, // compare and shift
		S_CLR   = 11'b00000100000, // clear union-find
		S_RD    = 11'b00001000000, // read sorted index
		S_EP    = 11'b00010000000, // read endpoints
		S_WALK  = 11'b00100000000, // walk to roots
		S_JOIN  = 11'b01000000000, // join roots
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [6:0] vcount_q;
	logic [EW:0] count_q, i_q, k_q;
	logic drop_q;
	logic [VW:0] nsel_q;

	// edge stores
	logic [11:0] ep_mem [MAX_EDGES];
	logic [31:0] eff_mem [MAX_EDGES];
	logic [31:0] prof_mem [MAX_EDGES];
	logic [EW-1:0] ord_mem [MAX_EDGES];
	logic [VW-1:0] par_mem [MAX_VERTICES];
	logic [2:0] rank_mem [MAX_VERTICES];

	logic [31:0] key_eff_q, key_prof_q, rd_eff_q, rd_prof_q;
	logic [EW-1:0] ord_rd_q, e_q;
	logic [11:0] ep_rd_q;
	logic [VW-1:0] pa_q, pb_q;
	logic [2:0] rka_q, rkb_q;
	logic [VW:0] clr_q;
	logic walk_ph_q;
	logic before_w;

	// the last selection is held back one beat so that it can carry last
	logic [EW-1:0] e_last_q;

	kss_cmp u_cmp (
		.a_effort(key_eff_q), .a_profit(key_prof_q),
		.b_effort(rd_eff_q), .b_profit(rd_prof_q), .before_ab(before_w)
	);

	logic [7:0] limit_w;
	assign limit_w = (32'(vcount_q) < MAX_VERTICES) ? 8'(vcount_q) : 8'(MAX_VERTICES);
	logic keep_w;
	assign keep_w = (8'(edge_in.edge_from) < limit_w) && (8'(edge_in.edge_to) < limit_w)
		&& (count_q < (EW+1)'(MAX_EDGES));

	assign busy = (state_q != S_IDLE);

	// store writes
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && keep_w) begin
			ep_mem[count_q[EW-1:0]]   <= {edge_in.edge_to, edge_in.edge_from};
			eff_mem[count_q[EW-1:0]]  <= edge_in.effort;
			prof_mem[count_q[EW-1:0]] <= edge_in.profit;
		end
	end

	// edge key read port (shared by sort fetch of key and of compare partner)
	logic [EW-1:0] krd_addr;
	always_comb begin
		krd_addr = (state_q == S_SI) ? i_q[EW-1:0] : ord_rd_q;
	end
	always_ff @(posedge clk) begin
		rd_eff_q  <= eff_mem[krd_addr];
		rd_prof_q <= prof_mem[krd_addr];
		ep_rd_q   <= ep_mem[ord_rd_q];
	end

	// order memory: one read, one write
	logic [EW-1:0] ord_raddr;
	logic ord_we;
	logic [EW-1:0] ord_waddr, ord_wdata;
	always_comb begin
		// partner index is held from its read until the compare
		if (state_q == S_SRD || state_q == S_SRD2) ord_raddr = EW'(k_q - 1'b1);
		else ord_raddr = i_q[EW-1:0];
		ord_we = 1'b0; ord_waddr = k_q[EW-1:0]; ord_wdata = ord_rd_q;
		if (state_q == S_SCMP) begin
			ord_we = 1'b1;
			if (k_q != '0 && before_w) ord_wdata = ord_rd_q;
			else ord_wdata = i_q[EW-1:0];
		end
	end
	always_ff @(posedge clk) begin
		if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
		ord_rd_q <= ord_mem[ord_raddr];
	end

	// rank bump of the surviving root, written the cycle after a join
	logic bump_q;
	logic [VW-1:0] bump_addr_q;
	logic [2:0] bump_rank_q;

	// union-find stores: single port, address by phase
	logic [VW-1:0] uf_addr;
	logic uf_we;
	logic [VW-1:0] uf_wpar;
	logic [2:0] uf_wrank;
	logic join_a_w;
	assign join_a_w = !(rka_q < rkb_q); // b under a
	always_comb begin
		uf_we = 1'b0; uf_wpar = clr_q[VW-1:0]; uf_wrank = '0;
		uf_addr = walk_ph_q ? pb_q : pa_q;
		if (state_q == S_CLR) begin
			uf_we = 1'b1; uf_addr = clr_q[VW-1:0];
		end else if (state_q == S_JOIN) begin
			uf_we = 1'b1;
			if (join_a_w) begin
				uf_addr = pb_q; uf_wpar = pa_q; uf_wrank = rkb_q;
			end else begin
				uf_addr = pa_q; uf_wpar = pb_q; uf_wrank = rka_q;
			end
		end else if (bump_q) begin
			// surviving root keeps itself as parent
			uf_we = 1'b1; uf_addr = bump_addr_q; uf_wpar = bump_addr_q;
			uf_wrank = bump_rank_q;
		end
	end
	logic [VW-1:0] par_rd_q;
	logic [2:0] rank_rd_q;
	always_ff @(posedge clk) begin
		if (uf_we) begin
			par_mem[uf_addr]  <= uf_wpar;
			rank_mem[uf_addr] <= uf_wrank;
		end
		par_rd_q  <= par_mem[uf_addr];
		rank_rd_q <= rank_mem[uf_addr];
	end

	// walk sub-phase: 0 issue read, 1 look at data
	logic wlook_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; vcount_q <= 7'd64; count_q <= '0; drop_q <= 1'b0;
			i_q <= '0; k_q <= '0; nsel_q <= '0; clr_q <= '0; walk_ph_q <= 1'b0;
			wlook_q <= 1'b0; res_strobe <= 1'b0; bump_q <= 1'b0;
		end else begin
			res_strobe <= 1'b0;
			bump_q <= 1'b0;
			if (cfg_we) vcount_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (keep_w) count_q <= count_q + 1'b1;
						else drop_q <= 1'b1;
						if (edge_in.last_edge) begin
							i_q <= '0;
							state_q <= S_SI;
						end
					end
				end
				S_SI: begin
					if (i_q == count_q) begin
						clr_q <= '0; state_q <= S_CLR;
					end else begin
						k_q <= i_q; state_q <= S_SRD;
					end
				end
				S_SRD: begin
					// key is fresh only on the first step of an outer pass
					if (k_q == i_q) begin
						key_eff_q <= rd_eff_q; key_prof_q <= rd_prof_q;
					end
					if (k_q == '0) state_q <= S_SCMP;
					else state_q <= S_SRD2;
				end
				S_SRD2: state_q <= S_SCMP; // partner keys land in rd_*_q
				S_SCMP: begin
					if (k_q != '0 && before_w) begin
						k_q <= k_q - 1'b1; state_q <= S_SRD;
					end else begin
						i_q <= i_q + 1'b1; state_q <= S_SI;
					end
				end
				S_CLR: begin
					if (clr_q == (VW+1)'(MAX_VERTICES - 1)) begin
						i_q <= '0; nsel_q <= '0; state_q <= S_RD;
					end
					clr_q <= clr_q + 1'b1;
				end
				S_RD: begin
					if (i_q == count_q || 32'(nsel_q) + 1 >= MAX_VERTICES) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_EP; wlook_q <= 1'b0;
					end
				end
				S_EP: begin
					if (!wlook_q) begin
						e_q <= ord_rd_q; wlook_q <= 1'b1;
					end else begin
						pa_q <= VW'(ep_rd_q[5:0]); pb_q <= VW'(ep_rd_q[11:6]);
						walk_ph_q <= 1'b0; wlook_q <= 1'b0; state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (bump_q) begin
						wlook_q <= 1'b0;
					end else if (!wlook_q) begin
						wlook_q <= 1'b1;
					end else begin
						wlook_q <= 1'b0;
						if (par_rd_q != (walk_ph_q ? pb_q : pa_q)) begin
							if (walk_ph_q) pb_q <= par_rd_q; else pa_q <= par_rd_q;
						end else if (!walk_ph_q) begin
							rka_q <= rank_rd_q; walk_ph_q <= 1'b1;
						end else begin
							rkb_q <= rank_rd_q;
							if (pa_q == pb_q) begin
								i_q <= i_q + 1'b1; state_q <= S_RD;
							end else begin
								state_q <= S_JOIN;
							end
						end
					end
				end
				S_JOIN: begin
					// emit the previous selection, hold this one
					if (nsel_q != '0) begin
						res_strobe <= 1'b1;
						res.edge_index <= 9'(e_last_q) + 9'd1;
						res.valid_res <= 1'b1;
						res.last <= 1'b0;
						res.overflow <= drop_q;
					end
					nsel_q <= nsel_q + 1'b1;
					if (join_a_w && rka_q == rkb_q && 32'(rka_q) < kss_pkg::RANK_MAX) begin
						bump_q <= 1'b1; bump_addr_q <= pa_q; bump_rank_q <= rka_q + 1'b1;
					end
					i_q <= i_q + 1'b1; state_q <= S_RD;
				end
				S_DONE: begin
					res_strobe <= 1'b1;
					res.last <= 1'b1;
					res.overflow <= drop_q;
					if (nsel_q == '0) begin
						res.edge_index <= '0; res.valid_res <= 1'b0;
					end else begin
						res.edge_index <= 9'(e_last_q) + 9'd1; res.valid_res <= 1'b1;
					end
					count_q <= '0; drop_q <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_JOIN) e_last_q <= e_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n) res_strobe |-> busy || $past(busy))
		else $error("result beat outside a run");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> (state_q == S_IDLE && count_q == '0))
		else $error("edge count not cleared after run");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= (EW+1)'(MAX_EDGES))
		else $error("edge count beyond capacity");
endmodule
